/* rtl/core/apool_pkg.sv */
// Shared types and constants for the 2-D average pooling stream block.
// Used by apool_ctrl, apool_dp and average_pool_2d_stream_unit.
`timescale 1ns / 1ps

package apool_pkg;

  // Register field widths and APB port geometry
  localparam int SIDE_W   = 4;
  localparam int DIM_W    = 11;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;
  localparam int REG_IX_W = 2;

  // Register indexes (byte address / 4)
  localparam logic [REG_IX_W-1:0] REG_WINDOW_SIDE   = 2'd0;
  localparam logic [REG_IX_W-1:0] REG_PLANE_COLUMNS = 2'd1;
  localparam logic [REG_IX_W-1:0] REG_PLANE_ROWS    = 2'd2;

  // Register reset values
  localparam logic [SIDE_W-1:0] WINDOW_SIDE_RST   = 4'd2;
  localparam logic [DIM_W-1:0]  PLANE_COLUMNS_RST = 11'd1024;
  localparam logic [DIM_W-1:0]  PLANE_ROWS_RST    = 11'd1024;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // latch sample and address, read the column sum
    logic acc;        // write the updated column sum
    logic first;      // first word of a window: overwrite instead of add
    logic start_div;  // start dividing the updated sum
    logic load_out;   // move the quotient into the output register
    logic last;       // end-of-plane flag for the loaded word
  } apool_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_busy;   // divider still iterating
    logic out_busy;   // output register holds a word that is stalled
  } apool_stat_t;

endpackage

/* rtl/core/apool_ctrl.sv */
// Controller of the average pooling block: state machine and raster position tracking.
// Depends on apool_pkg; drives apool_dp through apool_cmd_t.
`timescale 1ns / 1ps

module apool_ctrl
  import apool_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_WINDOW  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_clear,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   side,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]  cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]     rows,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  apool_stat_t                       stat,
  output apool_cmd_t                        cmd,
  output logic [$clog2(MAX_COLUMNS)-1:0]    addr
);

  localparam int KW      = $clog2(MAX_WINDOW + 1);
  localparam int OFF_W   = $clog2(MAX_WINDOW);
  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int ADDR_W  = $clog2(MAX_COLUMNS);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int RADDR_W = $clog2(MAX_ROWS);
  localparam int CPOS_W  = $clog2(MAX_COLUMNS + 2 * MAX_WINDOW + 1);
  localparam int RPOS_W  = $clog2(MAX_ROWS + 2 * MAX_WINDOW + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  col_pos_r, col_pos_nxt;
  logic [RADDR_W-1:0] row_pos_r, row_pos_nxt;
  logic [OFF_W-1:0]   wcol_off_r, wcol_off_nxt;
  logic [OFF_W-1:0]   wrow_off_r, wrow_off_nxt;
  logic [ADDR_W-1:0]  out_col_r, out_col_nxt;
  logic [ADDR_W-1:0]  win_col_r, win_col_nxt;
  logic [RADDR_W-1:0] win_row_r, win_row_nxt;
  logic               first_r, first_nxt;
  logic               emit_r, emit_nxt;
  logic               last_r, last_nxt;

  logic [OFF_W-1:0] side_m1;
  logic             accept;
  logic             col_active, row_active;
  logic             col_last, row_last;
  logic             end_of_row, end_of_plane;

  // Window geometry checks against the start of the current window
  assign side_m1      = OFF_W'(side - KW'(1));
  assign col_active   = (CPOS_W'(win_col_r) + CPOS_W'(side)) <= CPOS_W'(cols);
  assign row_active   = (RPOS_W'(win_row_r) + RPOS_W'(side)) <= RPOS_W'(rows);
  assign col_last     = (CPOS_W'(win_col_r) + CPOS_W'(side) + CPOS_W'(side)) > CPOS_W'(cols);
  assign row_last     = (RPOS_W'(win_row_r) + RPOS_W'(side) + RPOS_W'(side)) > RPOS_W'(rows);
  assign end_of_row   = CNT_W'(col_pos_r) == (cols - CNT_W'(1));
  assign end_of_plane = RCNT_W'(row_pos_r) == (rows - RCNT_W'(1));

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign addr     = out_col_r;

  // Next state, position advance and datapath commands
  always_comb begin
    state_nxt    = state_r;
    col_pos_nxt  = col_pos_r;
    row_pos_nxt  = row_pos_r;
    wcol_off_nxt = wcol_off_r;
    wrow_off_nxt = wrow_off_r;
    out_col_nxt  = out_col_r;
    win_col_nxt  = win_col_r;
    win_row_nxt  = win_row_r;
    first_nxt    = first_r;
    emit_nxt     = emit_r;
    last_nxt     = last_r;
    cmd          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (col_active && row_active) begin
            cmd.take  = 1'b1;
            first_nxt = (wcol_off_r == '0) && (wrow_off_r == '0);
            emit_nxt  = (wcol_off_r == side_m1) && (wrow_off_r == side_m1);
            last_nxt  = col_last && row_last;
            state_nxt = S_ACC;
            if (wcol_off_r == side_m1) begin
              wcol_off_nxt = '0;
              out_col_nxt  = out_col_r + ADDR_W'(1);
              win_col_nxt  = col_pos_r + ADDR_W'(1);
            end else begin
              wcol_off_nxt = wcol_off_r + OFF_W'(1);
            end
          end
          col_pos_nxt = col_pos_r + ADDR_W'(1);
          // wrap the row, then the plane
          if (end_of_row) begin
            col_pos_nxt  = '0;
            wcol_off_nxt = '0;
            out_col_nxt  = '0;
            win_col_nxt  = '0;
            row_pos_nxt  = row_pos_r + RADDR_W'(1);
            if (wrow_off_r == side_m1) begin
              wrow_off_nxt = '0;
              win_row_nxt  = row_pos_r + RADDR_W'(1);
            end else begin
              wrow_off_nxt = wrow_off_r + OFF_W'(1);
            end
            if (end_of_plane) begin
              row_pos_nxt  = '0;
              wrow_off_nxt = '0;
              win_row_nxt  = '0;
            end
          end
        end
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        cmd.first = first_r;
        if (emit_r) begin
          cmd.start_div = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.last     = last_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a register write starts a new plane
    if (cfg_clear) begin
      col_pos_nxt  = '0;
      row_pos_nxt  = '0;
      wcol_off_nxt = '0;
      wrow_off_nxt = '0;
      out_col_nxt  = '0;
      win_col_nxt  = '0;
      win_row_nxt  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      wcol_off_r <= '0;
      wrow_off_r <= '0;
      out_col_r  <= '0;
      win_col_r  <= '0;
      win_row_r  <= '0;
      first_r    <= 1'b0;
      emit_r     <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      wcol_off_r <= wcol_off_nxt;
      wrow_off_r <= wrow_off_nxt;
      out_col_r  <= out_col_nxt;
      win_col_r  <= win_col_nxt;
      win_row_r  <= win_row_nxt;
      first_r    <= first_nxt;
      emit_r     <= emit_nxt;
      last_r     <= last_nxt;
    end
  end

endmodule

/* rtl/core/apool_dp.sv */
// Datapath of the average pooling block: column-sum memory, bit-serial divider, output register.
// Depends on apool_pkg; commanded by apool_ctrl.
`timescale 1ns / 1ps

module apool_dp
  import apool_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_WINDOW  = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  apool_cmd_t                                cmd,
  input  logic [$clog2(MAX_COLUMNS)-1:0]            addr,
  input  logic signed [SAMPLE_BITS-1:0]             sample,
  input  logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0] divisor,
  output apool_stat_t                               stat,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_average,
  output logic                                      out_end_of_plane
);

  localparam int ADDR_W = $clog2(MAX_COLUMNS);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int DIV_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DCNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0] sum_mem [MAX_COLUMNS];

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [SUM_W-1:0]       rd_data_r;
  logic [SUM_W-1:0]       sum_new;
  logic [SUM_W-1:0]       sample_ext;
  logic [SUM_W-1:0]       sum_mag;

  logic [SUM_W-1:0]  div_q_r;
  logic [DIV_W-1:0]  div_rem_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              div_busy_r;
  logic              div_neg_r;
  logic [DIV_W:0]    rem_shift;
  logic              rem_ge;
  logic [DIV_W:0]    rem_diff;
  logic [SUM_W-1:0]  quot_signed;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_average_r;
  logic                   out_eop_r;

  // Sign-extend the sample and update the running column sum
  assign sample_ext = {{(SUM_W - SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign sum_new    = cmd.first ? sample_ext : (rd_data_r + sample_ext);
  assign sum_mag    = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;

  // Latch the word and read its column sum
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r  <= sample;
      addr_r    <= addr;
      rd_data_r <= sum_mem[addr];
    end
  end

  // Write back the updated sum
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sum_mem[addr_r] <= sum_new;
    end
  end

  // Restoring divider: one quotient bit per cycle on the magnitude
  assign rem_shift = {div_rem_r, div_q_r[SUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.start_div) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && (div_cnt_r == DCNT_W'(SUM_W - 1))) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      div_q_r   <= sum_mag;
      div_rem_r <= '0;
      div_cnt_r <= '0;
      div_neg_r <= sum_new[SUM_W-1];
    end else if (div_busy_r) begin
      div_q_r   <= {div_q_r[SUM_W-2:0], rem_ge};
      div_rem_r <= rem_ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  // Restore the sign: truncation toward zero
  assign quot_signed = div_neg_r ? (~div_q_r + SUM_W'(1)) : div_q_r;

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_average_r <= quot_signed[SAMPLE_BITS-1:0];
      out_eop_r     <= cmd.last;
    end
  end

  assign stat.div_busy   = div_busy_r;
  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_end_of_plane = out_eop_r;

endmodule

/* rtl/core/average_pool_2d_stream_unit.sv */
// Top level of the non-overlapping 2-D average pooling stream block.
// Depends on apool_pkg, apool_ctrl and apool_dp.
//
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one signed sample per word,
//   in raster order within a plane, planes back to back. Result channel
//   (out_valid / out_stall / out_average / out_end_of_plane) gives one word per
//   completed window: the window mean truncated toward zero, with end_of_plane
//   set on the last mean of a plane. Edge rows and columns that do not fill a
//   window are consumed without a result.
//   APB port holds window_side (0x0), plane_columns (0x4), plane_rows (0x8); any
//   write to these restarts the plane. Write only while the block is idle.
// Timing:
//   A sample outside every window is taken without a wait state. A sample inside a
//   window also passes S_ACC: the column-sum memory is read with registered data,
//   then written. A sample that completes a window then waits in S_DIV on the
//   bit-serial divider (SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW^2), 22 at default)
//   and in S_OUT for the load of the mean into the output register.
// Reset: registers return to 2 / 1024 / 1024, the plane position to its start.
//   Column sums need no clearing; a window's first sample overwrites its entry.
// Stall: the output register holds its word; a finished mean waits in the
//   divider until the register frees, and no input is taken meanwhile.
`timescale 1ns / 1ps

module average_pool_2d_stream_unit
  import apool_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_AW-1:0]             paddr,
  input  logic [APB_DW-1:0]             pwdata,
  output logic [APB_DW-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic                          out_end_of_plane
);

  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int ADDR_W = $clog2(MAX_COLUMNS);
  localparam int DIV_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int KCMP_W = (KW > SIDE_W) ? KW : SIDE_W;
  localparam int CCMP_W = (CNT_W > DIM_W) ? CNT_W : DIM_W;
  localparam int RCMP_W = (RCNT_W > DIM_W) ? RCNT_W : DIM_W;

  logic [SIDE_W-1:0] side_r;
  logic [DIM_W-1:0]  cols_r;
  logic [DIM_W-1:0]  rows_r;

  logic [REG_IX_W-1:0] reg_ix;
  logic                cfg_wr;
  logic                cfg_clear;

  logic [KW-1:0]     side_eff;
  logic [CNT_W-1:0]  cols_eff;
  logic [RCNT_W-1:0] rows_eff;
  logic [DIV_W-1:0]  divisor;

  apool_cmd_t        cmd;
  apool_stat_t       stat;
  logic [ADDR_W-1:0] addr;

  // APB register file
  assign pready = 1'b1;
  assign reg_ix = paddr[APB_AW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_wr) begin
      unique case (reg_ix) inside
        REG_WINDOW_SIDE, REG_PLANE_COLUMNS, REG_PLANE_ROWS: cfg_clear = 1'b1;
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= WINDOW_SIDE_RST;
      cols_r <= PLANE_COLUMNS_RST;
      rows_r <= PLANE_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (reg_ix)
        REG_WINDOW_SIDE:   side_r <= pwdata[SIDE_W-1:0];
        REG_PLANE_COLUMNS: cols_r <= pwdata[DIM_W-1:0];
        REG_PLANE_ROWS:    rows_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_ix)
      REG_WINDOW_SIDE:   prdata = {{(APB_DW - SIDE_W){1'b0}}, side_r};
      REG_PLANE_COLUMNS: prdata = {{(APB_DW - DIM_W){1'b0}}, cols_r};
      REG_PLANE_ROWS:    prdata = {{(APB_DW - DIM_W){1'b0}}, rows_r};
      default:           prdata = '0;
    endcase
  end

  // Clamp register values into their working ranges
  always_comb begin
    if (side_r == '0) begin
      side_eff = KW'(1);
    end else if (KCMP_W'(side_r) > KCMP_W'(MAX_WINDOW)) begin
      side_eff = KW'(MAX_WINDOW);
    end else begin
      side_eff = KW'(side_r);
    end

    if (cols_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (CCMP_W'(cols_r) > CCMP_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(cols_r);
    end

    if (rows_r == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (RCMP_W'(rows_r) > RCMP_W'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_r);
    end
  end

  // Window area, the divisor of every mean
  assign divisor = DIV_W'(side_eff) * DIV_W'(side_eff);

  apool_ctrl #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (cfg_clear),
    .side      (side_eff),
    .cols      (cols_eff),
    .rows      (rows_eff),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd),
    .addr      (addr)
  );

  apool_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .addr             (addr),
    .sample           (in_sample),
    .divisor          (divisor),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_average      (out_average),
    .out_end_of_plane (out_end_of_plane)
  );

  // No word is taken while a mean is being divided
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !stat.div_busy)
    else $error("input word accepted during divide");

  // The output register is never overwritten while its word is stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_busy)
    else $error("output register overwritten while stalled");

  // A loaded mean shows up on the result channel
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("loaded mean not presented");

  // A divide is only started together with a column-sum update
  a_div_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_div |-> cmd.acc)
    else $error("divide started without accumulation");

endmodule

/* tb/sv/average_pool_2d_stream_unit_tb.sv */
// Self-checking testbench for average_pool_2d_stream_unit: streams sample words
// through the block and checks every window mean against an in-bench predictor.
// Depends on apool_pkg and the average_pool_2d_stream_unit RTL.
`timescale 1ns / 1ps

module average_pool_2d_stream_unit_tb;
  import apool_pkg::*;

  localparam int MAX_COLUMNS  = 1024;
  localparam int MAX_ROWS     = 1024;
  localparam int MAX_WINDOW   = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT  = 2000;

  // Address with no register behind it: writes there are dropped
  localparam logic [REG_IX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          end_of_plane;
  } mean_word_t;

  // Predict window means and check the result stream against them
  class pool_scoreboard;
    logic [SIDE_W-1:0] side_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  rows_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       win_col;
    int unsigned       win_row;
    int unsigned       out_col;
    int                col_sums [MAX_COLUMNS];
    mean_word_t        want_q [$];
    int                mismatches;

    function new();
      side_reg   = WINDOW_SIDE_RST;
      cols_reg   = PLANE_COLUMNS_RST;
      rows_reg   = PLANE_ROWS_RST;
      mismatches = 0;
      restart_plane();
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void restart_plane();
      col_pos = 0;
      row_pos = 0;
      win_col = 0;
      win_row = 0;
      out_col = 0;
    endfunction

    // Apply a register write; any known register restarts the plane
    function void write_register(logic [REG_IX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_WINDOW_SIDE:   side_reg = data[SIDE_W-1:0];
        REG_PLANE_COLUMNS: cols_reg = data[DIM_W-1:0];
        REG_PLANE_ROWS:    rows_reg = data[DIM_W-1:0];
        default:           return;
      endcase
      restart_plane();
    endfunction

    // Accumulate one accepted sample and queue a mean when its window closes
    function void note_sample(logic signed [SAMPLE_BITS-1:0] s);
      int unsigned k;
      int unsigned w;
      int unsigned h;
      int unsigned wout;
      int unsigned hout;
      mean_word_t  mw;
      k    = clamp_dim(side_reg, MAX_WINDOW);
      w    = clamp_dim(cols_reg, MAX_COLUMNS);
      h    = clamp_dim(rows_reg, MAX_ROWS);
      wout = w / k;
      hout = h / k;
      if (col_pos < wout * k && row_pos < hout * k && out_col < MAX_COLUMNS) begin
        if (win_row == 0 && win_col == 0) col_sums[out_col] = s;
        else col_sums[out_col] += s;
        if (win_row == k - 1 && win_col == k - 1) begin
          mw.average      = SAMPLE_BITS'(col_sums[out_col] / int'(k * k));
          mw.end_of_plane = (row_pos == hout * k - 1) && (out_col == wout - 1);
          want_q.push_back(mw);
        end
        win_col++;
        if (win_col >= k) begin
          win_col = 0;
          out_col++;
        end
      end
      // Advance the raster position, wrapping rows and planes
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        win_col = 0;
        out_col = 0;
        row_pos++;
        win_row++;
        if (win_row >= k) win_row = 0;
        if (row_pos >= h) begin
          row_pos = 0;
          win_row = 0;
        end
      end
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] avg, logic eop);
      mean_word_t mw;
      if (want_q.size() == 0) begin
        mismatches++;
        $error("average: no word expected, got %0d", avg);
        return;
      end
      mw = want_q.pop_front();
      if (avg !== mw.average) begin
        mismatches++;
        $error("average: expected %0d, got %0d", mw.average, avg);
      end
      if (eop !== mw.end_of_plane) begin
        mismatches++;
        $error("end_of_plane: expected %0b, got %0b", mw.end_of_plane, eop);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_AW-1:0]             paddr;
  logic [APB_DW-1:0]             pwdata;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_average;
  logic                          out_end_of_plane;

  pool_scoreboard sb;
  logic           quiet;        // phase without sender gaps or receiver stalls
  int             stall_left;
  int             stuck_cycles;

  average_pool_2d_stream_unit #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .out_end_of_plane(out_end_of_plane)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take result words, draw the next stall, and watch for a hung block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_average, out_end_of_plane);
      stall_left = quiet ? 0 : $urandom_range(0, 3);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);

    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly small planes, with zero, maximum and oversized values now and then
  function automatic logic [31:0] draw_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(MAX_COLUMNS + 1, 2047);
      2:       return MAX_COLUMNS;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // APB write: setup, access, then idle on the bus
  task automatic write_reg(input logic [REG_IX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] data;
    data = value;
    if ($urandom_range(0, 1)) data = ($urandom & 32'hFFFF_F800) | value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup_plane(input logic [31:0] side, input logic [31:0] cols,
                             input logic [31:0] rows);
    write_reg(REG_WINDOW_SIDE, side);
    write_reg(REG_PLANE_COLUMNS, cols);
    write_reg(REG_PLANE_ROWS, rows);
  endtask

  // Offer one sample word after a random gap; valid stays high on return
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Drop valid and let every pending mean come out before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned total;
    int unsigned n;
    int unsigned plane;
    logic [31:0] side;
    logic [31:0] cols;
    logic [31:0] rows;
    sb         = new();
    quiet      = 1'b0;
    stall_left = 0;
    stuck_cycles = 0;
    rst_n     <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 windows: truncation toward zero on a negative sum, then full scale
    setup_plane(2, 2, 2);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(16'sh8001);
    repeat (4) send_sample(16'sh7FFF);
    drain();

    // zero side, columns and rows act as one
    setup_plane(0, 0, 0);
    send_sample(draw_sample());
    drain();

    // oversized side saturates to the max window; plane too small for it
    setup_plane(15, 2, 2);
    repeat (4) send_sample(draw_sample());
    drain();

    // leftover edge row and column; a write to no register keeps the position
    setup_plane(2, 3, 3);
    repeat (4) send_sample(draw_sample());
    drain();
    write_reg(REG_UNUSED, $urandom_range(1, 15));
    repeat (5) send_sample(draw_sample());
    drain();

    // Random phases: one full-width row first, then mixed plane shapes
    total = 0;
    while (total < RANDOM_ITEMS) begin
      if (total == 0) begin
        side = 1;
        cols = 2047;
        rows = 0;
      end else begin
        case ($urandom_range(0, 9))
          0:       side = 0;
          1:       side = $urandom_range(MAX_WINDOW + 1, 15);
          default: side = $urandom_range(1, MAX_WINDOW);
        endcase
        cols = draw_dim();
        rows = draw_dim();
      end
      plane = pool_scoreboard::clamp_dim(cols, MAX_COLUMNS) *
              pool_scoreboard::clamp_dim(rows, MAX_ROWS);
      if (total == 0) n = MAX_COLUMNS;
      else if (plane <= 600)
        n = plane * $urandom_range(1, 2) +
            (($urandom_range(0, 3) == 0) ? $urandom_range(0, plane - 1) : 0);
      else n = $urandom_range(60, 300);
      // keep the run near its item budget
      if (total + n > RANDOM_ITEMS) n = RANDOM_ITEMS - total;
      quiet = ($urandom_range(0, 3) == 0);
      setup_plane(side, cols, rows);
      for (int i = 0; i < n; i++) begin
        // hold off the sender until the block has emptied
        if ($urandom_range(0, 63) == 0) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_sample(draw_sample());
      end
      total += n;
      drain();
    end

    if (sb.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
